### design/cht_pkg.sv
`timescale 1ns / 1ps

package cht_pkg;

    // defaults for the top-level parameters
    localparam int BUCKETS_DEF    = 16;
    localparam int SLOTS_DEF      = 8;
    localparam int PRIME_DEF      = 97;
    localparam int KEY_BITS_DEF   = 16;
    localparam int VALUE_BITS_DEF = 32;

    // fixed field widths
    localparam int CFG_BITS     = 7;
    localparam int CFG_IDX_BITS = 1;
    localparam int OP_BITS      = 2;
    localparam int STATUS_BITS  = 2;
    localparam int COUNT_BITS   = 8;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_MULT   = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OFFSET = 1'd1;

    // opcodes
    localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_BITS-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_BITS-1:0] OP_DELETE = 2'd2;

    // status codes
    localparam logic [STATUS_BITS-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STATUS_BITS-1:0] STAT_FULL      = 2'd2;

    localparam logic [CFG_BITS-1:0] MULT_RESET   = 7'd1;
    localparam logic [CFG_BITS-1:0] OFFSET_RESET = 7'd0;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_FILL,
        ST_SCAN,
        ST_SHIFT,
        ST_MOVE
    } t_state;

endpackage

### design/chained_hash_table.sv
`timescale 1ns / 1ps

// Chained hash table: one request (insert, search, delete) at a time, taken when start is
// high and busy is low; its result appears on the o_ ports for exactly one cycle with o_valid
// and must be captured then. Latency is set by the hash pipeline, the registered fill-count
// memory read and the entry memory, which is walked one slot per cycle from the newest
// entry down: a search or delete compares slots until it finds the key or has compared the
// oldest entry, and a successful delete then moves each newer entry down one slot. A new
// request may be accepted in the o_valid cycle. After reset the block clears the fill count
// of every bucket with busy high; register writes are taken at any time but must only change
// while no request is in flight.
module chained_hash_table #(
    parameter int BUCKETS    = cht_pkg::BUCKETS_DEF,
    parameter int SLOTS      = cht_pkg::SLOTS_DEF,
    parameter int PRIME      = cht_pkg::PRIME_DEF,
    parameter int KEY_BITS   = cht_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = cht_pkg::VALUE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [cht_pkg::OP_BITS-1:0]         i_opcode,
    input  logic [KEY_BITS-1:0]                 i_lookup_key,
    input  logic [VALUE_BITS-1:0]               i_new_value,
    input  logic                                i_cfg_we,
    input  logic [cht_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [cht_pkg::CFG_BITS-1:0]        i_cfg_wdata,
    output logic                                o_valid,
    output logic [cht_pkg::STATUS_BITS-1:0]     o_status,
    output logic [VALUE_BITS-1:0]               o_found_value,
    output logic [cht_pkg::COUNT_BITS-1:0]      o_element_count
);
    import cht_pkg::*;

    localparam int AW = $clog2(BUCKETS * SLOTS);
    localparam int BW = $clog2(BUCKETS);
    localparam int FW = $clog2(SLOTS + 1);
    localparam logic [AW-1:0] SLOTS_A = AW'(SLOTS);
    localparam logic [FW-1:0] SLOTS_F = FW'(SLOTS);
    localparam logic [BW-1:0] LAST_B  = BW'(BUCKETS - 1);

    t_state                r_state, n_state;
    logic [OP_BITS-1:0]    r_op, n_op;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic [BW-1:0]         r_bucket, n_bucket;
    logic [FW-1:0]         r_fill, n_fill;
    logic [FW-1:0]         r_idx, n_idx;
    logic [BW-1:0]         r_clr, n_clr;
    logic [COUNT_BITS-1:0] r_total, n_total;
    logic [CFG_BITS-1:0]   r_mult;
    logic [CFG_BITS-1:0]   r_offset;
    logic                  r_valid, n_valid;
    logic [STATUS_BITS-1:0] r_status, n_status;
    logic [VALUE_BITS-1:0] r_found, n_found;
    logic [COUNT_BITS-1:0] r_count, n_count;

    logic                  hash_start;
    logic                  hash_valid;
    logic [BW-1:0]         hash_bucket;

    logic                  ent_we;
    logic [AW-1:0]         ent_waddr;
    logic [KEY_BITS-1:0]   ent_wkey;
    logic [VALUE_BITS-1:0] ent_wval;
    logic [AW-1:0]         ent_raddr;
    logic [KEY_BITS-1:0]   ent_rkey;
    logic [VALUE_BITS-1:0] ent_rval;
    logic                  fill_we;
    logic [BW-1:0]         fill_waddr;
    logic [FW-1:0]         fill_wdata;
    logic [BW-1:0]         fill_raddr;
    logic [FW-1:0]         fill_rdata;

    logic [AW-1:0]         base;
    logic [FW:0]           idx_up;

    assign busy       = (r_state != ST_IDLE) || !i_rst_n;
    assign hash_start = start && !busy;
    assign base       = AW'(r_bucket) * SLOTS_A;
    assign idx_up     = {1'b0, r_idx} + (FW+1)'(1);

    cht_hash #(
        .KEY_BITS (KEY_BITS),
        .PRIME    (PRIME),
        .BUCKETS  (BUCKETS)
    ) u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (hash_start),
        .i_key    (i_lookup_key),
        .i_mult   (r_mult),
        .i_offset (r_offset),
        .o_valid  (hash_valid),
        .o_bucket (hash_bucket)
    );

    cht_store #(
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS),
        .BUCKETS    (BUCKETS),
        .SLOTS      (SLOTS)
    ) u_store (
        .i_clk        (i_clk),
        .i_ent_we     (ent_we),
        .i_ent_waddr  (ent_waddr),
        .i_ent_wkey   (ent_wkey),
        .i_ent_wval   (ent_wval),
        .i_ent_raddr  (ent_raddr),
        .o_ent_rkey   (ent_rkey),
        .o_ent_rval   (ent_rval),
        .i_fill_we    (fill_we),
        .i_fill_waddr (fill_waddr),
        .i_fill_wdata (fill_wdata),
        .i_fill_raddr (fill_raddr),
        .o_fill_rdata (fill_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_total  <= '0;
            r_valid  <= 1'b0;
            r_mult   <= MULT_RESET;
            r_offset <= OFFSET_RESET;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_total <= n_total;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MULT:   r_mult   <= i_cfg_wdata;
                    CFG_OFFSET: r_offset <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_key    <= n_key;
        r_val    <= n_val;
        r_bucket <= n_bucket;
        r_fill   <= n_fill;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_found  <= n_found;
        r_count  <= n_count;
    end

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_key      = r_key;
        n_val      = r_val;
        n_bucket   = r_bucket;
        n_fill     = r_fill;
        n_idx      = r_idx;
        n_clr      = r_clr;
        n_total    = r_total;
        n_valid    = 1'b0;
        n_status   = r_status;
        n_found    = r_found;
        n_count    = r_count;
        ent_we     = 1'b0;
        ent_waddr  = base + AW'(r_idx);
        ent_wkey   = r_key;
        ent_wval   = r_val;
        ent_raddr  = base + AW'(r_idx);
        fill_we    = 1'b0;
        fill_waddr = r_bucket;
        fill_wdata = r_fill;
        fill_raddr = hash_bucket;

        case (r_state)
            ST_CLEAR: begin
                fill_we    = 1'b1;
                fill_waddr = r_clr;
                fill_wdata = '0;
                n_clr      = r_clr + BW'(1);
                if (r_clr == LAST_B) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_op    = i_opcode;
                    n_key   = i_lookup_key;
                    n_val   = i_new_value;
                    n_state = ST_HASH;
                end
            end
            ST_HASH: begin
                // fill count read is issued at the hashed bucket
                if (hash_valid) begin
                    n_bucket = hash_bucket;
                    n_state  = ST_FILL;
                end
            end
            ST_FILL: begin
                n_fill   = fill_rdata;
                n_found  = '0;
                n_status = STAT_OK;
                n_valid  = 1'b1;
                n_state  = ST_IDLE;
                case (r_op)
                    OP_INSERT: begin
                        if (fill_rdata >= SLOTS_F) begin
                            n_status = STAT_FULL;
                        end else begin
                            ent_we     = 1'b1;
                            ent_waddr  = base + AW'(fill_rdata);
                            fill_we    = 1'b1;
                            fill_wdata = fill_rdata + FW'(1);
                            n_total    = r_total + COUNT_BITS'(1);
                        end
                    end
                    OP_SEARCH, OP_DELETE: begin
                        if (fill_rdata == '0) begin
                            n_status = STAT_NOT_FOUND;
                        end else begin
                            // start at the newest entry of the bucket
                            n_valid   = 1'b0;
                            n_idx     = fill_rdata - FW'(1);
                            ent_raddr = base + AW'(fill_rdata - FW'(1));
                            n_state   = ST_SCAN;
                        end
                    end
                    default: ;
                endcase
            end
            ST_SCAN: begin
                if (ent_rkey == r_key) begin
                    if (r_op == OP_SEARCH) begin
                        n_valid  = 1'b1;
                        n_status = STAT_OK;
                        n_found  = ent_rval;
                        n_state  = ST_IDLE;
                    end else begin
                        n_state = ST_SHIFT;
                    end
                end else if (r_idx == '0) begin
                    n_valid  = 1'b1;
                    n_status = STAT_NOT_FOUND;
                    n_state  = ST_IDLE;
                end else begin
                    n_idx     = r_idx - FW'(1);
                    ent_raddr = base + AW'(r_idx - FW'(1));
                end
            end
            ST_SHIFT: begin
                if (idx_up >= {1'b0, r_fill}) begin
                    fill_we    = 1'b1;
                    fill_wdata = r_fill - FW'(1);
                    n_total    = r_total - COUNT_BITS'(1);
                    n_valid    = 1'b1;
                    n_status   = STAT_OK;
                    n_state    = ST_IDLE;
                end else begin
                    ent_raddr = base + AW'(idx_up);
                    n_state   = ST_MOVE;
                end
            end
            ST_MOVE: begin
                // newer neighbor moves down one slot
                ent_we   = 1'b1;
                ent_wkey = ent_rkey;
                ent_wval = ent_rval;
                n_idx    = idx_up[FW-1:0];
                n_state  = ST_SHIFT;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (n_valid) begin
            n_count = n_total;
        end
    end

    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_found_value   = r_found;
    assign o_element_count = r_count;

endmodule

### design/cht_mod.sv
`timescale 1ns / 1ps

// x mod DIV by reciprocal multiply, three register stages.
// q = floor(x * floor(2^W / DIV) / 2^W) undershoots by at most one,
// so one compare and subtract finishes the job.
module cht_mod #(
    parameter int IN_W  = 24,
    parameter int DIV   = 97,
    parameter int OUT_W = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [IN_W-1:0]  i_x,
    output logic             o_valid,
    output logic [OUT_W-1:0] o_r
);
    import cht_pkg::*;

    localparam int W = (IN_W > OUT_W) ? IN_W : OUT_W;
    localparam longint unsigned MULT = (64'd1 << W) / DIV;
    localparam logic [W-1:0] M_C   = W'(MULT);
    localparam logic [W-1:0] DIV_C = W'(DIV);

    logic [2:0]     r_vld;
    logic [W-1:0]   r_q;
    logic [W-1:0]   r_x1;
    logic [W-1:0]   r_t;
    logic [W-1:0]   r_x2;
    logic [W-1:0]   r_r;
    logic [W-1:0]   x_w;
    logic [2*W-1:0] prod;
    logic [2*W-1:0] t_full;
    logic [W-1:0]   diff;

    assign x_w    = W'(i_x);
    assign prod   = {{W{1'b0}}, x_w} * {{W{1'b0}}, M_C};
    assign t_full = {{W{1'b0}}, r_q} * {{W{1'b0}}, DIV_C};
    assign diff   = r_x2 - r_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_q  <= prod[2*W-1:W];
        r_x1 <= x_w;
        r_t  <= t_full[W-1:0];
        r_x2 <= r_x1;
        r_r  <= (diff >= DIV_C) ? (diff - DIV_C) : diff;
    end

    assign o_valid = r_vld[2];
    assign o_r     = r_r[OUT_W-1:0];

endmodule

### design/cht_hash.sv
`timescale 1ns / 1ps

// bucket = ((a*key + b) mod PRIME) mod BUCKETS
module cht_hash #(
    parameter int KEY_BITS = cht_pkg::KEY_BITS_DEF,
    parameter int PRIME    = cht_pkg::PRIME_DEF,
    parameter int BUCKETS  = cht_pkg::BUCKETS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [KEY_BITS-1:0]           i_key,
    input  logic [cht_pkg::CFG_BITS-1:0]  i_mult,
    input  logic [cht_pkg::CFG_BITS-1:0]  i_offset,
    output logic                          o_valid,
    output logic [$clog2(BUCKETS)-1:0]    o_bucket
);
    import cht_pkg::*;

    localparam int XW = KEY_BITS + CFG_BITS + 1;
    localparam int PW = $clog2(PRIME);
    localparam int BW = $clog2(BUCKETS);

    logic          r_vld0;
    logic [XW-1:0] r_x;
    logic [XW-1:0] x_c;
    logic          p_valid;
    logic [PW-1:0] p_rem;

    assign x_c = XW'(i_mult) * XW'(i_key) + XW'(i_offset);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else begin
            r_vld0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= x_c;
    end

    cht_mod #(
        .IN_W  (XW),
        .DIV   (PRIME),
        .OUT_W (PW)
    ) u_mod_prime (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld0),
        .i_x     (r_x),
        .o_valid (p_valid),
        .o_r     (p_rem)
    );

    cht_mod #(
        .IN_W  (PW),
        .DIV   (BUCKETS),
        .OUT_W (BW)
    ) u_mod_bucket (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (p_valid),
        .i_x     (p_rem),
        .o_valid (o_valid),
        .o_r     (o_bucket)
    );

endmodule

### design/cht_store.sv
`timescale 1ns / 1ps

// entry memory (key, value) and per-bucket fill memory, registered reads
module cht_store #(
    parameter int KEY_BITS   = cht_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = cht_pkg::VALUE_BITS_DEF,
    parameter int BUCKETS    = cht_pkg::BUCKETS_DEF,
    parameter int SLOTS      = cht_pkg::SLOTS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_ent_we,
    input  logic [$clog2(BUCKETS*SLOTS)-1:0]      i_ent_waddr,
    input  logic [KEY_BITS-1:0]                   i_ent_wkey,
    input  logic [VALUE_BITS-1:0]                 i_ent_wval,
    input  logic [$clog2(BUCKETS*SLOTS)-1:0]      i_ent_raddr,
    output logic [KEY_BITS-1:0]                   o_ent_rkey,
    output logic [VALUE_BITS-1:0]                 o_ent_rval,
    input  logic                                  i_fill_we,
    input  logic [$clog2(BUCKETS)-1:0]            i_fill_waddr,
    input  logic [$clog2(SLOTS+1)-1:0]            i_fill_wdata,
    input  logic [$clog2(BUCKETS)-1:0]            i_fill_raddr,
    output logic [$clog2(SLOTS+1)-1:0]            o_fill_rdata
);
    import cht_pkg::*;

    localparam int DEPTH = BUCKETS * SLOTS;
    localparam int EW    = KEY_BITS + VALUE_BITS;
    localparam int FW    = $clog2(SLOTS + 1);

    logic [EW-1:0] r_ent_mem  [DEPTH];
    logic [FW-1:0] r_fill_mem [BUCKETS];
    logic [EW-1:0] r_ent_q;
    logic [FW-1:0] r_fill_q;

    always_ff @(posedge i_clk) begin
        if (i_ent_we) begin
            r_ent_mem[i_ent_waddr] <= {i_ent_wkey, i_ent_wval};
        end
        r_ent_q <= r_ent_mem[i_ent_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_fill_we) begin
            r_fill_mem[i_fill_waddr] <= i_fill_wdata;
        end
        r_fill_q <= r_fill_mem[i_fill_raddr];
    end

    assign o_ent_rkey   = r_ent_q[EW-1:VALUE_BITS];
    assign o_ent_rval   = r_ent_q[VALUE_BITS-1:0];
    assign o_fill_rdata = r_fill_q;

endmodule

### design/cht_checker.sv
`timescale 1ns / 1ps

module cht_checker #(
    parameter int VALUE_BITS = cht_pkg::VALUE_BITS_DEF
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              o_valid,
    input logic [cht_pkg::STATUS_BITS-1:0]   o_status,
    input logic [VALUE_BITS-1:0]             o_found_value
);
    import cht_pkg::*;

    // an accepted request keeps the block busy until its result
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request accepted but block not busy");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == STAT_OK || o_status == STAT_NOT_FOUND ||
                     o_status == STAT_FULL))
        else $error("undefined status code");

    a_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != STAT_OK |-> o_found_value == '0)
        else $error("found value nonzero on failed request");

    // every request passes through the hash pipeline, so strobes never touch
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("back-to-back result strobes");

    a_result_needs_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without a request in flight");

endmodule

bind chained_hash_table cht_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_cht_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_status      (o_status),
    .o_found_value (o_found_value)
);
